>>> rtl/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// No dependencies; imported by htd_walker and huffman_tree_decoder.
package htd_pkg;

    localparam int MAX_NODES    = 1024;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int NODE_W       = $clog2(MAX_NODES);
    localparam int CNT_W        = $clog2(MAX_NODES + 1);
    localparam int LEN_W        = $clog2(LEN_LIMIT + 1);
    localparam int CODE_IW      = $clog2(CODE_W);
    localparam int IN_LEN_W     = 6;
    localparam int SYM_W        = 9;
    localparam int TALLY_W      = 32;

    localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_DECODE  = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    // result kinds
    typedef enum logic [2:0] {
        K_SYMBOL  = 3'd0,
        K_END     = 3'd1,
        K_INVALID = 3'd2,
        K_NOSYM   = 3'd3,
        K_DONE    = 3'd4,
        K_FULL    = 3'd5,
        K_IGNORED = 3'd6
    } kind_t;

    // one node table entry
    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic              leaf;
        logic [SYM_W-1:0]  sym;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    // one result item
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         sym;
        logic [TALLY_W-1:0] count;
        logic               last;
    } result_t;

endpackage

>>> rtl/htd_node_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data holds when no read is issued. No dependencies.
module htd_node_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 30,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we_i,
    input  logic [AW-1:0]    waddr_i,
    input  logic [WIDTH-1:0] wdata_i,
    input  logic             re_i,
    input  logic [AW-1:0]    raddr_i,
    output logic [WIDTH-1:0] rdata_o
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re_i) begin
            rdata_reg <= mem[raddr_i];
        end
    end

    assign rdata_o = rdata_reg;

endmodule

>>> rtl/htd_walker.sv
// Command sequencer: walks the node table for insert and decode, one node
// read per step, and posts results through a one-deep hold stage.
// Depends on htd_pkg.
module htd_walker import htd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request side
    input  logic                 in_valid_i,
    output logic                 in_ready_o,
    input  cmd_t                 cmd_i,
    input  logic [CODE_W-1:0]    code_bits_i,
    input  logic [IN_LEN_W-1:0]  code_length_i,
    input  logic [SYM_W-1:0]     symbol_i,
    input  logic [7:0]           data_byte_i,
    // result side
    input  logic                 out_free_i,
    output logic                 push_o,
    output result_t              push_res_o,
    // node table
    output logic                 ram_we_o,
    output logic [NODE_W-1:0]    ram_waddr_o,
    output node_t                ram_wdata_o,
    output logic                 ram_re_o,
    output logic [NODE_W-1:0]    ram_raddr_o,
    input  node_t                ram_rdata_i
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_INS_WAIT = 5'b00010,
        ST_INS_STEP = 5'b00100,
        ST_DEC_NODE = 5'b01000,
        ST_FLUSH    = 5'b10000
    } state_t;

    state_t              state_reg,   state_next;
    logic [CODE_W-1:0]   code_reg,    code_next;
    logic [LEN_W-1:0]    rem_reg,     rem_next;
    logic [SYM_W-1:0]    sym_reg,     sym_next;
    logic [7:0]          byte_reg,    byte_next;
    logic [3:0]          bits_reg,    bits_next;
    logic [NODE_W-1:0]   cur_reg,     cur_next;
    node_t               node_reg,    node_next;
    logic                chk_reg,     chk_next;
    logic [CNT_W-1:0]    used_reg,    used_next;
    logic [NODE_W-1:0]   walk_reg,    walk_next;
    logic                fin_reg,     fin_next;
    logic [TALLY_W-1:0]  tally_reg,   tally_next;
    result_t             hold_reg,    hold_next;
    logic                hold_vld_reg, hold_vld_next;

    logic                post_en;
    result_t             post_res;
    logic                post_ok;
    logic                ins_bit;
    logic [NODE_W-1:0]   ins_child;
    logic                dec_bit;
    logic [NODE_W-1:0]   dec_nxt;
    logic [TALLY_W-1:0]  tally_inc;
    node_t               wr_node;

    assign in_ready_o = (state_reg == ST_IDLE);
    assign post_ok    = !hold_vld_reg || out_free_i;
    assign tally_inc  = (tally_reg != '1) ? tally_reg + TALLY_W'(1) : tally_reg;
    assign ins_bit    = code_reg[CODE_IW'(rem_reg - LEN_W'(1))];
    assign ins_child  = ins_bit ? node_reg.right : node_reg.left;
    assign dec_bit    = byte_reg[3'(bits_reg - 4'd1)];
    assign dec_nxt    = dec_bit ? ram_rdata_i.right : ram_rdata_i.left;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        rem_next      = rem_reg;
        sym_next      = sym_reg;
        byte_next     = byte_reg;
        bits_next     = bits_reg;
        cur_next      = cur_reg;
        node_next     = node_reg;
        chk_next      = chk_reg;
        used_next     = used_reg;
        walk_next     = walk_reg;
        fin_next      = fin_reg;
        tally_next    = tally_reg;
        post_en       = 1'b0;
        post_res      = '{kind: K_NOSYM, sym: 8'd0, count: tally_reg, last: 1'b0};
        ram_we_o      = 1'b0;
        ram_waddr_o   = cur_reg;
        wr_node       = node_reg;
        ram_re_o      = 1'b0;
        ram_raddr_o   = walk_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid_i) begin
                    case (cmd_i)
                        CMD_CLEAR: begin
                            used_next     = '0;
                            walk_next     = '0;
                            post_en       = 1'b1;
                            post_res.kind = K_DONE;
                            state_next    = ST_FLUSH;
                        end
                        CMD_INSERT: begin
                            code_next = code_bits_i;
                            rem_next  = LEN_W'(code_length_i);
                            sym_next  = symbol_i;
                            if (code_length_i > IN_LEN_W'(LEN_LIMIT) ||
                                symbol_i > END_SYMBOL) begin
                                post_en       = 1'b1;
                                post_res.kind = K_IGNORED;
                                state_next    = ST_FLUSH;
                            end else if (used_reg == '0) begin
                                // create the root in place
                                cur_next   = '0;
                                node_next  = '0;
                                used_next  = CNT_W'(1);
                                state_next = ST_INS_STEP;
                            end else begin
                                cur_next    = '0;
                                ram_re_o    = 1'b1;
                                ram_raddr_o = '0;
                                state_next  = ST_INS_WAIT;
                            end
                        end
                        CMD_DECODE: begin
                            byte_next = data_byte_i;
                            bits_next = 4'd8;
                            chk_next  = 1'b0;
                            if (fin_reg) begin
                                post_en       = 1'b1;
                                post_res.kind = K_IGNORED;
                                state_next    = ST_FLUSH;
                            end else if (CNT_W'(walk_reg) >= used_reg) begin
                                fin_next      = 1'b1;
                                post_en       = 1'b1;
                                post_res.kind = K_INVALID;
                                state_next    = ST_FLUSH;
                            end else begin
                                ram_re_o    = 1'b1;
                                ram_raddr_o = walk_reg;
                                state_next  = ST_DEC_NODE;
                            end
                        end
                        CMD_RESTART: begin
                            walk_next      = '0;
                            fin_next       = 1'b0;
                            tally_next     = '0;
                            post_en        = 1'b1;
                            post_res.kind  = K_NOSYM;
                            post_res.count = '0;
                            state_next     = ST_FLUSH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_INS_WAIT: begin
                node_next  = ram_rdata_i;
                state_next = ST_INS_STEP;
            end

            ST_INS_STEP: begin
                if (post_ok) begin
                    if (rem_reg == '0) begin
                        // mark the final node as a leaf
                        wr_node.leaf  = 1'b1;
                        wr_node.sym   = sym_reg;
                        ram_we_o      = 1'b1;
                        post_en       = 1'b1;
                        post_res.kind = K_DONE;
                        state_next    = ST_FLUSH;
                    end else if (ins_child != '0) begin
                        cur_next    = ins_child;
                        rem_next    = rem_reg - LEN_W'(1);
                        ram_re_o    = 1'b1;
                        ram_raddr_o = ins_child;
                        state_next  = ST_INS_WAIT;
                    end else if (used_reg >= CNT_W'(MAX_NODES)) begin
                        // store the node as it stands, no leaf
                        ram_we_o      = 1'b1;
                        post_en       = 1'b1;
                        post_res.kind = K_FULL;
                        state_next    = ST_FLUSH;
                    end else begin
                        // link a fresh node and move onto it
                        if (ins_bit) begin
                            wr_node.right = NODE_W'(used_reg);
                        end else begin
                            wr_node.left  = NODE_W'(used_reg);
                        end
                        ram_we_o  = 1'b1;
                        cur_next  = NODE_W'(used_reg);
                        node_next = '0;
                        used_next = used_reg + CNT_W'(1);
                        rem_next  = rem_reg - LEN_W'(1);
                    end
                end
            end

            ST_DEC_NODE: begin
                if (post_ok) begin
                    if (chk_reg && ram_rdata_i.leaf) begin
                        if (ram_rdata_i.sym == END_SYMBOL) begin
                            fin_next      = 1'b1;
                            post_en       = 1'b1;
                            post_res.kind = K_END;
                            state_next    = ST_FLUSH;
                        end else begin
                            tally_next     = tally_inc;
                            walk_next      = '0;
                            post_en        = 1'b1;
                            post_res.kind  = K_SYMBOL;
                            post_res.sym   = ram_rdata_i.sym[7:0];
                            post_res.count = tally_inc;
                            if (bits_reg == 4'd0) begin
                                state_next = ST_FLUSH;
                            end else begin
                                // back to the root for the next bit
                                chk_next    = 1'b0;
                                ram_re_o    = 1'b1;
                                ram_raddr_o = '0;
                            end
                        end
                    end else if (bits_reg == 4'd0) begin
                        if (!hold_vld_reg) begin
                            post_en       = 1'b1;
                            post_res.kind = K_NOSYM;
                        end
                        state_next = ST_FLUSH;
                    end else if (dec_nxt == '0 || CNT_W'(dec_nxt) >= used_reg) begin
                        fin_next      = 1'b1;
                        post_en       = 1'b1;
                        post_res.kind = K_INVALID;
                        state_next    = ST_FLUSH;
                    end else begin
                        walk_next   = dec_nxt;
                        bits_next   = bits_reg - 4'd1;
                        chk_next    = 1'b1;
                        ram_re_o    = 1'b1;
                        ram_raddr_o = dec_nxt;
                    end
                end
            end

            ST_FLUSH: begin
                if (out_free_i) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wdata_o = wr_node;

    // hold stage: a result leaves once its successor or the item end is known
    always_comb begin
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        push_o        = 1'b0;
        push_res_o    = hold_reg;
        if (state_reg == ST_FLUSH) begin
            if (out_free_i) begin
                push_o          = hold_vld_reg;
                push_res_o.last = 1'b1;
                hold_vld_next   = 1'b0;
            end
        end else if (post_en) begin
            push_o          = hold_vld_reg;
            push_res_o.last = 1'b0;
            hold_next       = post_res;
            hold_vld_next   = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            walk_reg     <= '0;
            fin_reg      <= 1'b0;
            tally_reg    <= '0;
            hold_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            walk_reg     <= walk_next;
            fin_reg      <= fin_next;
            tally_reg    <= tally_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        rem_reg  <= rem_next;
        sym_reg  <= sym_next;
        byte_reg <= byte_next;
        bits_reg <= bits_next;
        cur_reg  <= cur_next;
        node_reg <= node_next;
        chk_reg  <= chk_next;
        hold_reg <= hold_next;
    end

endmodule

>>> rtl/huffman_tree_decoder.sv
// Huffman tree decoder: takes clear, insert, decode and restart commands; insert
// and decode walk the node table with one node table read per step, and a step
// stalls while an earlier result still waits to be taken.
// One request is worked at a time; the next is taken while results still wait.
// aresetn (synchronous, active low) empties the tree, rewinds the walk and
// clears the symbol count; node table contents are not cleared.
module huffman_tree_decoder import htd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // code_bits[31:0], code_length[37:32],
                                        // symbol[46:38], data_byte[54:47], zero pad
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // symbol_out[7:0], decoded_count[39:8]
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    logic               out_free;
    logic               push;
    result_t            push_res;
    logic               ram_we;
    logic [NODE_W-1:0]  ram_waddr;
    node_t              ram_wdata;
    logic               ram_re;
    logic [NODE_W-1:0]  ram_raddr;
    logic [NODE_BITS-1:0] ram_rdata;
    logic               m_vld_reg;
    result_t            m_res_reg;

    // sequencer
    htd_walker u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid_i    (s_axis_tvalid),
        .in_ready_o    (s_axis_tready),
        .cmd_i         (cmd_t'(s_axis_tuser)),
        .code_bits_i   (s_axis_tdata[31:0]),
        .code_length_i (s_axis_tdata[37:32]),
        .symbol_i      (s_axis_tdata[46:38]),
        .data_byte_i   (s_axis_tdata[54:47]),
        .out_free_i    (out_free),
        .push_o        (push),
        .push_res_o    (push_res),
        .ram_we_o      (ram_we),
        .ram_waddr_o   (ram_waddr),
        .ram_wdata_o   (ram_wdata),
        .ram_re_o      (ram_re),
        .ram_raddr_o   (ram_raddr),
        .ram_rdata_i   (node_t'(ram_rdata))
    );

    // node table
    htd_node_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (NODE_BITS),
        .AW    (NODE_W)
    ) u_node_ram (
        .aclk    (aclk),
        .we_i    (ram_we),
        .waddr_i (ram_waddr),
        .wdata_i (ram_wdata),
        .re_i    (ram_re),
        .raddr_i (ram_raddr),
        .rdata_o (ram_rdata)
    );

    // result output register
    assign out_free = !m_vld_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (out_free) begin
            m_vld_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && push) begin
            m_res_reg <= push_res;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {m_res_reg.count, m_res_reg.sym};
    assign m_axis_tuser  = m_res_reg.kind;
    assign m_axis_tlast  = m_res_reg.last;

endmodule
